// ----- rtl/core/qbp_pkg.sv -----
// Shared types, character codes and limits for the quantifier bounds parser.
package qbp_pkg;

   // Field limits
   localparam int MaxDigits  = 5;
   localparam int ValueWidth = 17;
   localparam int CountWidth = 4;
   localparam int DigitWidth = 3;
   localparam int CharWidth  = 8;

   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [DigitWidth-1:0] digit_count_type;
   typedef logic [CharWidth-1:0]  char_type;

   // Token characters
   localparam char_type CHAR_NUL   = 8'h00;
   localparam char_type CHAR_DOT   = 8'h2E;
   localparam char_type CHAR_OPEN  = 8'h7B;
   localparam char_type CHAR_COMMA = 8'h2C;
   localparam char_type CHAR_CLOSE = 8'h7D;
   localparam char_type CHAR_ZERO  = 8'h30;
   localparam char_type CHAR_NINE  = 8'h39;

   // Slot of ". { min , max }" being parsed
   typedef enum logic [5:0] {
      POS_DOT   = 6'b000001,
      POS_OPEN  = 6'b000010,
      POS_MIN   = 6'b000100,
      POS_SEP   = 6'b001000,
      POS_MAX   = 6'b010000,
      POS_CLOSE = 6'b100000
   } fmt_pos_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FORMAT = 2'd1,
      STATUS_DIGITS = 2'd2,
      STATUS_RANGE  = 2'd3
   } status_type;

   typedef struct packed {
      fmt_pos_type     pos;
      digit_count_type digit_count;
      value_type       min_acc;
      value_type       max_acc;
      count_type       accepted;
      logic            finished;
   } parse_state_type;

   typedef struct packed {
      status_type status;
      value_type  min_value;
      value_type  max_value;
      count_type  consumed;
   } result_type;

endpackage

// ----- rtl/core/quantifier_bounds_parser.sv -----
// Top level of the quantifier bounds parser: input register, parse state, result register.
// Parses ".", ".{min,max}" and ".{size}" tokens one character per transfer; a
// character with req_start_req high opens a new token and latches csr_default_max
// as the default maximum. The block takes one character every cycle unless input is stalled.
// A character is held in the input register until it is advanced. If it ends the
// token, the edge that advances it loads its result into the result register,
// which drives rsp_valid. Input is stalled only while a finished result
// waits in the result register and the character in the input register would make
// another. rsp_min_value and rsp_max_value read zero unless rsp_status is ok;
// rsp_consumed counts the token characters taken before parsing ended.
// csr_default_max should be written only while no token is in flight.
module quantifier_bounds_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  qbp_pkg::value_type  csr_default_max,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_start_req,
   input  qbp_pkg::char_type   req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qbp_pkg::status_type rsp_status,
   output qbp_pkg::value_type  rsp_min_value,
   output qbp_pkg::value_type  rsp_max_value,
   output qbp_pkg::count_type  rsp_consumed
);
   import qbp_pkg::*;

   value_type       default_max_ff;
   logic            in_valid_ff;
   logic            in_start_ff;
   char_type        in_char_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            rsp_valid_ff;
   result_type      rsp_ff;
   result_type      step_result;
   logic            step_emit;
   logic            out_free;
   logic            fire;

   // hold the configured default maximum
   always_ff @(posedge clock) begin
      if (reset) begin
         default_max_ff <= '0;
      end else if (csr_write_enable) begin
         default_max_ff <= csr_default_max;
      end
   end

   qbp_step u_step (
      .state_cur   (state_ff),
      .start_req   (in_start_ff),
      .char_code   (in_char_ff),
      .default_max (default_max_ff),
      .state_nxt   (state_in),
      .emit        (step_emit),
      .result      (step_result)
   );

   // advance the held character unless its result has nowhere to go
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && (!step_emit || out_free);
   assign req_ready = !in_valid_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_start_ff <= req_start_req;
         in_char_ff  <= req_char_code;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pos         <= POS_DOT;
         state_ff.digit_count <= '0;
         state_ff.min_acc     <= '0;
         state_ff.max_acc     <= '0;
         state_ff.accepted    <= '0;
         state_ff.finished    <= 1'b1;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && step_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && step_emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_ff.status;
   assign rsp_min_value = rsp_ff.min_value;
   assign rsp_max_value = rsp_ff.max_value;
   assign rsp_consumed  = rsp_ff.consumed;

endmodule

// ----- rtl/core/qbp_step.sv -----
// Next-state and result logic for one token character.
module qbp_step (
   input  qbp_pkg::parse_state_type state_cur,
   input  logic                     start_req,
   input  qbp_pkg::char_type        char_code,
   input  qbp_pkg::value_type       default_max,
   output qbp_pkg::parse_state_type state_nxt,
   output logic                     emit,
   output qbp_pkg::result_type      result
);
   import qbp_pkg::*;

   parse_state_type s;
   fmt_pos_type     eff_pos;
   status_type      status_raw;
   logic            is_digit;
   logic [3:0]      digit_val;
   value_type       acc_sel;
   value_type       acc_new;

   always_comb begin
      is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      digit_val = 4'(char_code - CHAR_ZERO);
   end

   always_comb begin
      s          = state_cur;
      emit       = 1'b0;
      status_raw = STATUS_OK;
      eff_pos    = state_cur.pos;
      acc_sel    = '0;
      acc_new    = '0;

      // restart the token on a start flag
      if (start_req) begin
         s.pos         = POS_DOT;
         s.digit_count = '0;
         s.min_acc     = '0;
         s.max_acc     = default_max;
         s.accepted    = '0;
         s.finished    = 1'b0;
      end
      eff_pos = s.pos;

      if (!s.finished) begin
         // close a number field on a non-digit and fall through to the next slot
         if ((s.pos == POS_MIN || s.pos == POS_MAX) && !is_digit) begin
            s.digit_count = '0;
            eff_pos       = (s.pos == POS_MIN) ? POS_SEP : POS_CLOSE;
            s.pos         = eff_pos;
         end

         acc_sel = (eff_pos == POS_MIN) ? s.min_acc : s.max_acc;
         acc_new = (s.digit_count == '0) ? value_type'(digit_val)
                 : value_type'((acc_sel << 3) + (acc_sel << 1) + value_type'(digit_val));

         case (eff_pos)
            POS_MIN, POS_MAX: begin
               // accumulate one decimal digit
               if (s.digit_count >= DigitWidth'(MaxDigits)) begin
                  emit       = 1'b1;
                  status_raw = STATUS_DIGITS;
               end else begin
                  if (eff_pos == POS_MIN) begin
                     s.min_acc = acc_new;
                  end else begin
                     s.max_acc = acc_new;
                  end
                  s.digit_count = s.digit_count + 1'b1;
                  s.accepted    = s.accepted + 1'b1;
               end
            end
            POS_DOT, POS_OPEN: begin
               if (char_code == CHAR_NUL) begin
                  emit = 1'b1;
               end else if (char_code == ((eff_pos == POS_DOT) ? CHAR_DOT : CHAR_OPEN)) begin
                  s.accepted = s.accepted + 1'b1;
                  s.pos      = (eff_pos == POS_DOT) ? POS_OPEN : POS_MIN;
               end else begin
                  emit       = 1'b1;
                  status_raw = STATUS_FORMAT;
               end
            end
            POS_SEP: begin
               if (char_code == CHAR_NUL) begin
                  emit = 1'b1;
               end else if (char_code == CHAR_COMMA) begin
                  s.accepted = s.accepted + 1'b1;
                  s.pos      = POS_MAX;
               end else if (char_code == CHAR_CLOSE) begin
                  // early brace: single size
                  s.accepted = s.accepted + 1'b1;
                  s.max_acc  = s.min_acc;
                  emit       = 1'b1;
               end else begin
                  emit       = 1'b1;
                  status_raw = STATUS_FORMAT;
               end
            end
            POS_CLOSE: begin
               if (char_code == CHAR_NUL) begin
                  emit = 1'b1;
               end else if (char_code == CHAR_CLOSE) begin
                  s.accepted = s.accepted + 1'b1;
                  emit       = 1'b1;
               end else begin
                  emit       = 1'b1;
                  status_raw = STATUS_FORMAT;
               end
            end
            default: begin
               emit       = 1'b1;
               status_raw = STATUS_FORMAT;
            end
         endcase

         if (emit) begin
            s.finished = 1'b1;
         end
      end

      state_nxt = s;
   end

   // bound check and result formatting
   always_comb begin
      result.status = status_raw;
      if (status_raw == STATUS_OK && state_nxt.max_acc < state_nxt.min_acc) begin
         result.status = STATUS_RANGE;
      end
      result.min_value = (result.status == STATUS_OK) ? state_nxt.min_acc : '0;
      result.max_value = (result.status == STATUS_OK) ? state_nxt.max_acc : '0;
      result.consumed  = state_nxt.accepted;
   end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the quantifier bounds parser with a scoreboard class.
module tb_top;
   import qbp_pkg::*;

   // Predict the bounds result of each accepted character and check the responses
   class bounds_scoreboard;
      value_type    default_max;
      int unsigned  slot;
      int unsigned  digits;
      value_type    min_acc;
      value_type    max_acc;
      count_type    accepted;
      bit           finished;
      result_type   expected_bounds[$];
      int unsigned  errors;
      int unsigned  results_checked;

      function new();
         default_max     = '0;
         slot            = 0;
         digits          = 0;
         min_acc         = '0;
         max_acc         = '0;
         accepted        = '0;
         finished        = 1'b1;
         errors          = 0;
         results_checked = 0;
      endfunction

      function void set_default_max(value_type v);
         default_max = v;
      endfunction

      function int unsigned pending();
         return expected_bounds.size();
      endfunction

      // Literal character expected in each fixed slot of ". { min , max }"
      function char_type slot_char(int unsigned p);
         case (p)
            0: return CHAR_DOT;
            1: return CHAR_OPEN;
            3: return CHAR_COMMA;
            5: return CHAR_CLOSE;
            default: return CHAR_NUL;
         endcase
      endfunction

      // Close the token and queue its result
      function void close_token(status_type s);
         result_type r;
         if (s == STATUS_OK && max_acc < min_acc) s = STATUS_RANGE;
         r.status    = s;
         r.min_value = (s == STATUS_OK) ? min_acc : '0;
         r.max_value = (s == STATUS_OK) ? max_acc : '0;
         r.consumed  = accepted;
         expected_bounds.push_back(r);
         finished = 1'b1;
      endfunction

      // Advance the parse state by one accepted character
      function void note_char(bit start, char_type ch);
         int unsigned p;
         int unsigned d;
         bit          done;
         if (start) begin
            slot     = 0;
            digits   = 0;
            min_acc  = '0;
            max_acc  = default_max;
            accepted = '0;
            finished = 1'b0;
         end
         if (finished) return;
         done = 1'b0;
         while (!done) begin
            p    = slot;
            done = 1'b1;
            if (p > 5) begin
               close_token(STATUS_OK);
            end else if (p == 2 || p == 4) begin
               if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                  d = int'(ch) - int'(CHAR_ZERO);
                  if (digits >= MaxDigits) begin
                     close_token(STATUS_DIGITS);
                  end else begin
                     if (p == 2)
                        min_acc = (digits == 0) ? value_type'(d) : value_type'(min_acc * 10 + d);
                     else
                        max_acc = (digits == 0) ? value_type'(d) : value_type'(max_acc * 10 + d);
                     digits++;
                     accepted++;
                  end
               end else begin
                  // Field ends here; an empty field keeps its default
                  digits = 0;
                  slot   = p + 1;
                  if (ch == CHAR_NUL) close_token(STATUS_OK);
                  else done = 1'b0;
               end
            end else if (ch == CHAR_NUL) begin
               close_token(STATUS_OK);
            end else if (ch == slot_char(p)) begin
               accepted++;
               slot = p + 1;
               if (slot > 5) close_token(STATUS_OK);
            end else if (p == 3 && ch == CHAR_CLOSE) begin
               // Brace right after the minimum: a single size
               accepted++;
               max_acc = min_acc;
               close_token(STATUS_OK);
            end else begin
               close_token(STATUS_FORMAT);
            end
         end
      endfunction

      // Compare one response with the oldest expected result
      function void check_bounds(status_type s, value_type mn, value_type mx, count_type c);
         result_type e;
         if (expected_bounds.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: status %0d min %0d max %0d consumed %0d",
                     $time, s, mn, mx, c);
            return;
         end
         e = expected_bounds.pop_front();
         results_checked++;
         if (s !== e.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, s);
         end
         if (mn !== e.min_value) begin
            errors++;
            $display("%0t: min_value mismatch: expected %0d, actual %0d", $time, e.min_value, mn);
         end
         if (mx !== e.max_value) begin
            errors++;
            $display("%0t: max_value mismatch: expected %0d, actual %0d", $time, e.max_value, mx);
         end
         if (c !== e.consumed) begin
            errors++;
            $display("%0t: consumed mismatch: expected %0d, actual %0d", $time, e.consumed, c);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   value_type  csr_default_max;
   logic       req_valid;
   logic       req_ready;
   logic       req_start_req;
   char_type   req_char_code;
   logic       rsp_valid;
   logic       rsp_ready;
   status_type rsp_status;
   value_type  rsp_min_value;
   value_type  rsp_max_value;
   count_type  rsp_consumed;

   bounds_scoreboard bounds_sb;
   char_type         tok[$];
   int unsigned      chars_sent = 0;
   int unsigned      tokens_sent = 0;
   int unsigned      settings_used = 0;
   bit               req_idle_on = 1'b1;
   bit               rsp_idle_on = 1'b1;
   bit               hold_off_active = 1'b0;
   int               rsp_gap = 0;
   event             hold_off_start;

   quantifier_bounds_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_default_max  (csr_default_max),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_req    (req_start_req),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_min_value    (rsp_min_value),
      .rsp_max_value    (rsp_max_value),
      .rsp_consumed     (rsp_consumed)
   );

   // Clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Observe transfers on both channels
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         bounds_sb.note_char(req_start_req, req_char_code);
      if (!reset && rsp_valid && rsp_ready)
         bounds_sb.check_bounds(rsp_status, rsp_min_value, rsp_max_value, rsp_consumed);
   end

   // Receiver: random stall bursts, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_off_active) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
         rsp_gap   <= $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Long hold-off of the receiver, counted in its own process
   initial forever begin
      @(hold_off_start);
      hold_off_active <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off_active <= 1'b0;
   end

   // Give up after a generous fixed time
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

   // Offer one character, with an optional idle burst first; return at its transfer
   task automatic send_char(bit start, char_type ch);
      int gap;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      req_char_code <= ch;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   task automatic send_token();
      foreach (tok[i]) send_char(i == 0, tok[i]);
      tokens_sent++;
   endtask

   task automatic load_text(string s);
      tok.delete();
      for (int i = 0; i < s.len(); i++) tok.push_back(char_type'(s[i]));
   endtask

   function automatic char_type random_digit();
      return char_type'(CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   // Mostly one to four digits, sometimes full-width, empty or one digit too many
   function automatic int field_digits();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return 6;
      if (r < 8) return 5;
      return $urandom_range(1, 4);
   endfunction

   // Build ".{min,max}" or ".{size}" with random digits
   task automatic build_well_formed();
      int n;
      tok.delete();
      tok.push_back(CHAR_DOT);
      tok.push_back(CHAR_OPEN);
      n = field_digits();
      repeat (n) tok.push_back(random_digit());
      if ($urandom_range(0, 3) == 0) begin
         tok.push_back(CHAR_CLOSE);
      end else begin
         tok.push_back(CHAR_COMMA);
         n = field_digits();
         repeat (n) tok.push_back(random_digit());
         tok.push_back(CHAR_CLOSE);
      end
   endtask

   // Pick a token shape: well-formed, cut short, corrupted or noise
   task automatic make_random_token();
      int kind;
      int n;
      int idx;
      kind = $urandom_range(0, 99);
      build_well_formed();
      if (kind < 55) begin
         if ($urandom_range(0, 7) == 0) tok[tok.size()-1] = CHAR_NUL;
      end else if (kind < 70) begin
         n = $urandom_range(1, tok.size() - 1);
         while (tok.size() > n) void'(tok.pop_back());
         case ($urandom_range(0, 2))
            0: tok.push_back(CHAR_NUL);
            1: tok.push_back(char_type'($urandom_range(0, 255)));
            default: ;  // leave it open so the next start drops it
         endcase
      end else if (kind < 88) begin
         idx = $urandom_range(0, tok.size() - 1);
         case ($urandom_range(0, 5))
            0: tok[idx] = CHAR_COMMA;
            1: tok[idx] = CHAR_CLOSE;
            2: tok[idx] = CHAR_NUL;
            3: tok[idx] = random_digit();
            default: tok[idx] = char_type'($urandom_range(0, 255));
         endcase
      end else begin
         tok.delete();
         n = $urandom_range(1, 6);
         repeat (n) tok.push_back(char_type'($urandom_range(0, 255)));
      end
      // Sometimes add trailing characters; after a result they are ignored
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) tok.push_back(char_type'($urandom_range(0, 255)));
      end
   endtask

   task automatic write_default_max(value_type v);
      csr_default_max  <= v;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bounds_sb.set_default_max(v);
      settings_used++;
   endtask

   // Close any open token, then wait until the block has gone quiet
   task automatic settle();
      send_char(1'b0, CHAR_NUL);
      req_valid <= 1'b0;
      // let the monitor note the last transfer and the input register drain
      repeat (2) @(posedge clock);
      while (bounds_sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      value_type   dm;
      int unsigned target;
      int unsigned phase_start;
      bounds_sb        = new();
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_default_max  = '0;
      req_valid        = 1'b0;
      req_start_req    = 1'b0;
      req_char_code    = CHAR_NUL;
      rsp_ready        = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed tokens
      write_default_max(17'h1FFFF);
      load_text(".{1");
      send_token();
      load_text(".{99999,3}");
      send_token();
      load_text(".{9}");
      send_token();
      send_char(1'b0, 8'hFF);
      load_text(".{123456");
      send_token();
      send_char(1'b1, 8'hFF);
      load_text(".{,");
      tok.push_back(CHAR_NUL);
      send_token();
      settle();

      // Random tokens over several default maximum settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: dm = '0;
            1: dm = 17'h1FFFF;
            2: dm = value_type'($urandom_range(0, 99999));
            3: dm = value_type'(5);
            4: dm = value_type'($urandom_range(0, 131071));
            default: dm = value_type'($urandom_range(0, 200));
         endcase
         write_default_max(dm);
         phase_start = chars_sent;
         target      = chars_sent + 320;
         if (ph == 2) begin
            req_idle_on = 1'b0;
            -> hold_off_start;
         end
         if (ph == 5) begin
            req_idle_on = 1'b0;
            rsp_idle_on <= 1'b0;
         end
         while (chars_sent < target) begin
            make_random_token();
            send_token();
            if (ph == 2 && !req_idle_on && chars_sent >= phase_start + 60)
               req_idle_on = 1'b1;
         end
         settle();
      end

      $display("Covered %0d characters in %0d tokens under %0d default maximum settings.",
               chars_sent, tokens_sent, settings_used);
      $display("Checked %0d results, including a long receiver hold-off.",
               bounds_sb.results_checked);
      if (bounds_sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- quantifier_bounds_parser.f -----
rtl/core/qbp_pkg.sv
rtl/core/qbp_step.sv
rtl/core/quantifier_bounds_parser.sv
tb/tb_top.sv
